/* hdl/assert_macros.svh */
// Assertion macros used by the checker file.
// Each macro assumes signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

/* hdl/bggc_pkg.sv */
// Shared constants, payload types and the control/status bundles of the colouring block.
// No dependencies.
package bggc_pkg;

   localparam int MAX_NODES   = 1024;
   localparam int MAX_COLOURS = 16;

   localparam int NODE_W  = 10;                       // fixed width of node fields
   localparam int NODE_AW = $clog2(MAX_NODES);
   localparam int CI_W    = $clog2(MAX_COLOURS);      // colour index width
   localparam int CNT_W   = $clog2(MAX_COLOURS + 1);  // colours-in-use count width
   localparam int USE_W   = 11;
   localparam logic [USE_W-1:0] USES_MAX = 11'd2047;

   // Node memory word: valid, epoch, colour index.
   localparam int EPOCH_W = 4;
   localparam int MEM_W   = 1 + EPOCH_W + CI_W;

   // Least-used search: groups of GRP counts, then the group winners.
   localparam int GRP  = 4;
   localparam int NGRP = (MAX_COLOURS + GRP - 1) / GRP;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic [NODE_W-1:0] neighbour;
      logic              has_neighbour;
      logic              last_of_node;
      logic              start_graph;
   } bggc_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node_out;
      logic [3:0]        colour;
      logic              opened_new;
      logic [4:0]        colours_used;
      logic              error;
   } bggc_rsp_type;

   typedef struct packed {
      logic load;     // latch accepted beat
      logic look;     // neighbour colour read back
      logic sel_a;    // search, first level
      logic sel_b;    // search, second level
      logic commit;   // store colour, write result
      logic sweep;    // clearing pass over node memory
   } bggc_cmd_type;

   typedef struct packed {
      logic last;        // latched beat ends its node
      logic wrap;        // epoch at its final value
      logic sweep_done;  // clearing pass at last entry
   } bggc_sts_type;

endpackage

/* hdl/balanced_greedy_graph_colouring_top.sv */
// Balanced greedy graph colouring, top level; uses bggc_pkg, bggc_ctrl, bggc_dp (bggc_ram).
// A non-start beat that does not end its node does a lookup (one registered read of the node-colour RAM).
// A beat ending its node then runs both search levels and the commit, which waits for a free result slot.
// A start beat skips the lookup; every sixteenth graph start adds a clearing pass over the whole node-colour RAM.
// Reset is synchronous; after it a clearing pass clears the node-colour RAM, with req_ready low.
module balanced_greedy_graph_colouring_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  bggc_pkg::bggc_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output bggc_pkg::bggc_rsp_type rsp_data
);
   import bggc_pkg::*;

   bggc_cmd_type cmd;
   bggc_sts_type sts;

   bggc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_start (req_data.start_graph),
      .req_last  (req_data.last_of_node),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bggc_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .sts      (sts),
      .req_data (req_data),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/bggc_ram.sv */
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module bggc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/bggc_ctrl.sv */
// Sequencer of the colouring block: handshakes, node-memory clearing, search and commit steps.
// Depends on bggc_pkg.
module bggc_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_start,
   input  logic                  req_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output bggc_pkg::bggc_cmd_type cmd,
   input  bggc_pkg::bggc_sts_type sts
);
   import bggc_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_LOOK   = 3'd2;
   localparam logic [2:0] ST_SEL_A  = 3'd3;
   localparam logic [2:0] ST_SEL_B  = 3'd4;
   localparam logic [2:0] ST_COMMIT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       pend_ff, pend_in;        // sweep was started by a beat, not by reset
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   always_comb begin
      slot_free = !rsp_valid_ff || rsp_ready;
      state_in  = state_ff;
      pend_in   = pend_ff;
      cmd       = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep = 1'b1;
            if (sts.sweep_done) begin
               pend_in  = 1'b0;
               state_in = (pend_ff && sts.last) ? ST_SEL_A : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_start) begin
                  // fresh graph: nothing is coloured, so no lookup
                  if (sts.wrap) begin
                     pend_in  = 1'b1;
                     state_in = ST_CLEAR;
                  end else if (req_last) begin
                     state_in = ST_SEL_A;
                  end
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            cmd.look = 1'b1;
            state_in = sts.last ? ST_SEL_A : ST_IDLE;
         end
         ST_SEL_A: begin
            cmd.sel_a = 1'b1;
            state_in  = ST_SEL_B;
         end
         ST_SEL_B: begin
            cmd.sel_b = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* hdl/bggc_dp.sv */
// Datapath of the colouring block: node-colour memory, blocked mask, use counts,
// two-level least-used search and result register. Depends on bggc_pkg and bggc_ram.
module bggc_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  bggc_pkg::bggc_cmd_type cmd,
   output bggc_pkg::bggc_sts_type sts,
   input  bggc_pkg::bggc_req_type req_data,
   output bggc_pkg::bggc_rsp_type rsp_data
);
   import bggc_pkg::*;

   bggc_req_type             item_ff, item_in;
   logic [MAX_COLOURS-1:0]   blocked_ff, blocked_in;
   logic [USE_W-1:0]         uses_ff [MAX_COLOURS];
   logic [USE_W-1:0]         uses_in [MAX_COLOURS];
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [EPOCH_W-1:0]       epoch_ff, epoch_in;
   logic [NODE_AW-1:0]       sweep_ff, sweep_in;

   logic [NGRP-1:0]          grp_found_ff, grp_found_in;
   logic [CI_W-1:0]          grp_idx_ff [NGRP];
   logic [CI_W-1:0]          grp_idx_in [NGRP];
   logic [USE_W-1:0]         grp_uses_ff [NGRP];
   logic [USE_W-1:0]         grp_uses_in [NGRP];

   logic                     found_ff, found_in;
   logic [CI_W-1:0]          best_ff, best_in;
   logic [USE_W-1:0]         best_uses;

   bggc_rsp_type             rsp_ff, rsp_in;

   // node memory
   logic                     wr_en;
   logic [NODE_AW-1:0]       wr_addr;
   logic [MEM_W-1:0]         wr_data;
   logic [NODE_AW-1:0]       rd_addr;
   logic [MEM_W-1:0]         rd_data;

   logic                     rd_valid;
   logic [EPOCH_W-1:0]       rd_epoch;
   logic [CI_W-1:0]          rd_colour;
   logic                     hit;

   logic                     node_ok;
   logic                     can_open;
   logic                     c_err;
   logic                     c_open;
   logic [CI_W-1:0]          c_best;
   logic [CNT_W-1:0]         c_count;

   assign rd_addr = NODE_AW'(req_data.neighbour);

   bggc_ram #(
      .WIDTH (MEM_W),
      .DEPTH (MAX_NODES)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // An entry counts only if written in the current epoch.
   always_comb begin
      rd_valid  = rd_data[MEM_W-1];
      rd_epoch  = rd_data[CI_W +: EPOCH_W];
      rd_colour = rd_data[CI_W-1:0];
      hit = item_ff.has_neighbour && (32'(item_ff.neighbour) < MAX_NODES) && rd_valid &&
            (rd_epoch == epoch_ff) && (32'(rd_colour) < MAX_COLOURS);
   end

   // Search, level one: best open, unblocked colour within each group.
   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_found_in[g] = 1'b0;
         grp_idx_in[g]   = '0;
         grp_uses_in[g]  = '0;
         for (int k = 0; k < GRP; k++) begin
            if (g * GRP + k < MAX_COLOURS) begin
               if ((CNT_W'(g * GRP + k) < count_ff) && !blocked_ff[g * GRP + k] &&
                   (!grp_found_in[g] || (uses_ff[g * GRP + k] < grp_uses_in[g]))) begin
                  grp_found_in[g] = 1'b1;
                  grp_idx_in[g]   = CI_W'(g * GRP + k);
                  grp_uses_in[g]  = uses_ff[g * GRP + k];
               end
            end
         end
      end
   end

   // Search, level two: strict compare in index order keeps ties on the lowest index.
   always_comb begin
      found_in  = 1'b0;
      best_in   = '0;
      best_uses = '0;
      for (int g = 0; g < NGRP; g++) begin
         if (grp_found_ff[g] && (!found_in || (grp_uses_ff[g] < best_uses))) begin
            found_in  = 1'b1;
            best_in   = grp_idx_ff[g];
            best_uses = grp_uses_ff[g];
         end
      end
   end

   always_comb begin
      node_ok  = 32'(item_ff.node) < MAX_NODES;
      can_open = 32'(count_ff) < MAX_COLOURS;
      c_err    = !node_ok || (!found_ff && !can_open);
      c_open   = node_ok && !found_ff && can_open;
      c_best   = found_ff ? best_ff : CI_W'(count_ff);
      c_count  = c_open ? CNT_W'(count_ff + 1'b1) : count_ff;
   end

   always_comb begin
      item_in    = item_ff;
      blocked_in = blocked_ff;
      uses_in    = uses_ff;
      count_in   = count_ff;
      epoch_in   = epoch_ff;
      rsp_in     = rsp_ff;

      if (cmd.load) begin
         item_in = req_data;
         if (req_data.start_graph) begin
            blocked_in = '0;
            count_in   = '0;
            epoch_in   = epoch_ff + 1'b1;
            for (int j = 0; j < MAX_COLOURS; j++) begin
               uses_in[j] = '0;
            end
         end
      end

      if (cmd.look && hit) begin
         blocked_in[rd_colour] = 1'b1;
      end

      if (cmd.commit) begin
         blocked_in = '0;
         count_in   = c_count;
         if (!c_err && (uses_ff[c_best] != USES_MAX)) begin
            uses_in[c_best] = uses_ff[c_best] + 1'b1;
         end
         rsp_in.node_out     = item_ff.node;
         rsp_in.colour       = c_err ? 4'd0 : 4'(c_best);
         rsp_in.opened_new   = c_open;
         rsp_in.colours_used = 5'(c_count);
         rsp_in.error        = c_err;
      end

      sweep_in = cmd.sweep ? sweep_ff + 1'b1 : '0;

      wr_en   = cmd.sweep || (cmd.commit && !c_err);
      wr_addr = cmd.sweep ? sweep_ff : NODE_AW'(item_ff.node);
      wr_data = cmd.sweep ? '0 : {1'b1, epoch_ff, c_best};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         count_ff   <= '0;
         epoch_ff   <= '0;
         sweep_ff   <= '0;
         for (int j = 0; j < MAX_COLOURS; j++) begin
            uses_ff[j] <= '0;
         end
      end else begin
         blocked_ff <= blocked_in;
         count_ff   <= count_in;
         epoch_ff   <= epoch_in;
         sweep_ff   <= sweep_in;
         uses_ff    <= uses_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
      if (cmd.sel_a) begin
         grp_found_ff <= grp_found_in;
         grp_idx_ff   <= grp_idx_in;
         grp_uses_ff  <= grp_uses_in;
      end
      if (cmd.sel_b) begin
         found_ff <= found_in;
         best_ff  <= best_in;
      end
   end

   assign sts.last       = item_ff.last_of_node;
   assign sts.wrap       = &epoch_ff;
   assign sts.sweep_done = (sweep_ff == NODE_AW'(MAX_NODES - 1));
   assign rsp_data       = rsp_ff;

endmodule

/* hdl/bggc_checker.sv */
// Port-level checks for the colouring block, bound to the top level.
// Depends on bggc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bggc_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input bggc_pkg::bggc_req_type req_data,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input bggc_pkg::bggc_rsp_type rsp_data
);
   import bggc_pkg::*;

   `ASSERT_CLK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp beat dropped")
   `ASSERT_CLK(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp_data), "rsp beat changed")
   `ASSERT_IMPLIES(a_err_clean, rsp_valid && rsp_data.error, rsp_data.colour == 4'd0 && !rsp_data.opened_new, "error beat carries a colour")
   `ASSERT_IMPLIES(a_open_next, rsp_valid && rsp_data.opened_new, 5'(rsp_data.colour) == rsp_data.colours_used - 5'd1, "opened colour is not the newest")

endmodule

bind balanced_greedy_graph_colouring_top bggc_checker u_bggc_checker (.*);

/* sim/balanced_greedy_graph_colouring_top_test.sv */
// Testbench for balanced_greedy_graph_colouring_top: directed runs, then random graphs.
// Depends on bggc_pkg and the top level; a local predictor checks every result beat.
`timescale 1ns / 1ps

module balanced_greedy_graph_colouring_top_test;
   import bggc_pkg::*;

   localparam int RUN_LIMIT   = 600000;
   localparam int IDLE_PCT    = 38;
   localparam int RANDOM_BEATS = 900;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   bggc_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   bggc_rsp_type rsp_data;

   // predicted graph state
   bit             coloured  [MAX_NODES];
   bit [CI_W-1:0]  colour_of [MAX_NODES];
   bit [USE_W-1:0] uses      [MAX_COLOURS];
   bit [CNT_W-1:0] in_use;
   bit [MAX_COLOURS-1:0] blocked;

   bggc_rsp_type colourings_due[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  beats_sent = 0;
   bit  calm = 1'b0;

   balanced_greedy_graph_colouring_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == RUN_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic bggc_req_type make_beat(input int node, input int nb, input bit has_nb,
                                              input bit last, input bit start);
      bggc_req_type beat;
      beat.node          = node[NODE_W-1:0];
      beat.neighbour     = nb[NODE_W-1:0];
      beat.has_neighbour = has_nb;
      beat.last_of_node  = last;
      beat.start_graph   = start;
      return beat;
   endfunction

   function automatic void predict_colouring(input bggc_req_type beat);
      bggc_rsp_type outcome;
      bit found, opened, err;
      int best;
      bit [USE_W-1:0] best_uses;
      found = 1'b0;
      opened = 1'b0;
      err = 1'b0;
      best = 0;
      best_uses = '0;
      if (beat.start_graph) begin
         foreach (coloured[n]) coloured[n] = 1'b0;
         foreach (uses[c]) uses[c] = '0;
         in_use = '0;
         blocked = '0;
      end
      if (beat.has_neighbour && coloured[beat.neighbour])
         blocked[colour_of[beat.neighbour]] = 1'b1;
      if (!beat.last_of_node)
         return;
      // least-used free color among those open, lowest index wins ties
      for (int c = 0; c < in_use; c++) begin
         if (!blocked[c] && (!found || uses[c] < best_uses)) begin
            found = 1'b1;
            best = c;
            best_uses = uses[c];
         end
      end
      if (!found) begin
         if (in_use < MAX_COLOURS) begin
            best = in_use;
            in_use++;
            opened = 1'b1;
            found = 1'b1;
         end else begin
            err = 1'b1;
         end
      end
      if (found) begin
         coloured[beat.node] = 1'b1;
         colour_of[beat.node] = best[CI_W-1:0];
         if (uses[best] != USES_MAX)
            uses[best]++;
      end
      blocked = '0;
      outcome.node_out     = beat.node;
      outcome.colour       = err ? 4'd0 : best[3:0];
      outcome.opened_new   = opened;
      outcome.colours_used = in_use;
      outcome.error        = err;
      colourings_due.push_back(outcome);
   endfunction

   function automatic void check_colouring(input bggc_rsp_type got);
      bggc_rsp_type want;
      if (colourings_due.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("result beat with nothing pending: %p", got);
         return;
      end
      want = colourings_due.pop_front();
      if (got.node_out !== want.node_out || got.colour !== want.colour ||
          got.opened_new !== want.opened_new || got.colours_used !== want.colours_used ||
          got.error !== want.error) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch at cycle %0d: expected %p, got %p", cycles, want, got);
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         check_colouring(rsp_data);
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   task automatic send_beat(input bggc_req_type beat);
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      predict_colouring(beat);
      beats_sent++;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic wait_colourings_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (colourings_due.size() != 0);
   endtask

   task automatic test_single_beats();
      send_beat(make_beat(0, 1023, 0, 1, 1));
      send_beat(make_beat(1023, 0, 1, 1, 0));
      send_beat(make_beat(512, 1023, 1, 1, 0));
      send_beat(make_beat(3, 700, 1, 1, 0));      // neighbor never colored
      send_beat(make_beat(1023, 0, 1, 0, 0));
      send_beat(make_beat(1023, 1023, 0, 0, 0));  // no neighbor, junk fields
      send_beat(make_beat(9, 1023, 1, 1, 0));
      send_beat(make_beat(9, 9, 1, 1, 0));        // recolor, self blocks old color
      send_beat(make_beat(0, 0, 1, 0, 1));        // start on a non-final beat
      send_beat(make_beat(0, 1023, 1, 1, 0));
      send_beat(make_beat(700, 0, 1, 0, 0));
      send_beat(make_beat(5, 0, 1, 1, 1));        // start in the middle of a run
      send_beat(make_beat(682, 341, 1, 1, 0));
      send_beat(make_beat(341, 682, 1, 1, 0));
   endtask

   // clique of 17 nodes: the last one finds every color blocked and none left
   task automatic test_colours_exhausted();
      int base;
      base = $urandom_range(1000, 0);
      for (int k = 0; k <= MAX_COLOURS + 2; k++) begin
         if (k == 0) begin
            send_beat(make_beat(base, $urandom_range(1023), 0, 1, 1));
         end else if (k > MAX_COLOURS) begin
            // errored node must stay uncolored, so it blocks nothing
            send_beat(make_beat(base + k, base + MAX_COLOURS, 1, 1, 0));
         end else begin
            for (int j = 0; j < k; j++)
               send_beat(make_beat(j == k - 1 ? base + k : $urandom_range(1023),
                                   base + j, 1, j == k - 1, 0));
         end
      end
   endtask

   task automatic run_random_graph();
      int n_nodes, n_nb, nbeats, span, pick, node, nb;
      bit dense, first, has_nb, last;
      int placed[$];
      dense = ($urandom_range(9) == 0);
      n_nodes = dense ? $urandom_range(20, 16) : $urandom_range(16, 2);
      span = $urandom_range(1) ? 63 : 1023;
      first = 1'b1;
      repeat (n_nodes) begin
         if ($urandom_range(29) == 0)
            send_beat(make_beat($urandom_range(1023), $urandom_range(1023),
                                1'($urandom_range(1)), 1'($urandom_range(1)),
                                $urandom_range(49) == 0));
         if (placed.size() != 0 && $urandom_range(9) == 0)
            node = placed[$urandom_range(placed.size() - 1)];
         else
            node = $urandom_range(span);
         n_nb = dense ? placed.size() : $urandom_range(6);
         nbeats = n_nb == 0 ? 1 : n_nb;
         for (int i = 0; i < nbeats; i++) begin
            last = (i == nbeats - 1);
            pick = $urandom_range(9);
            if (dense)
               nb = placed[i];
            else if (pick < 6 && placed.size() != 0)
               nb = placed[$urandom_range(placed.size() - 1)];
            else if (pick == 6)
               nb = node;
            else
               nb = $urandom_range(span);
            has_nb = (n_nb != 0) && ($urandom_range(9) != 0);
            send_beat(make_beat(last ? node : $urandom_range(1023),
                                has_nb ? nb : $urandom_range(1023),
                                has_nb, last, first || ($urandom_range(99) == 0)));
            first = 1'b0;
         end
         placed.push_back(node);
      end
   endtask

   task automatic test_random_graphs();
      int graph_no, start_beats;
      graph_no = 0;
      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         calm = (graph_no >= 10 && graph_no < 16);
         run_random_graph();
         graph_no++;
         if (graph_no % 8 == 0)
            wait_colourings_done();
      end
      calm = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_single_beats();
      wait_colourings_done();
      test_colours_exhausted();
      wait_colourings_done();
      test_random_graphs();
      wait_colourings_done();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
